### sv/uyvyrot_pkg.sv
// ---------------------------------------------------------------------------
// uyvyrot_pkg
// Shared types, constants and helpers for the UYVY 90/270 frame rotator.
// ---------------------------------------------------------------------------
package uyvyrot_pkg;

  localparam int unsigned DefMaxWidth  = 640;
  localparam int unsigned DefMaxHeight = 480;

  localparam logic [9:0] WidthReset  = 10'd640;
  localparam logic [8:0] HeightReset = 9'd480;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_DIRECTION = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EMIT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic is_read;
    logic odd;
    logic ccw;
    logic last;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam int unsigned OpBits = $bits(op_t);

  function automatic logic [7:0] luma_at(input logic [31:0] word, input logic odd);
    return odd ? word[31:24] : word[15:8];
  endfunction

endpackage

### sv/uyvyrot_fifo.sv
// ---------------------------------------------------------------------------
// uyvyrot_fifo
// Two-word queue between the command front end and the frame store back end.
// ---------------------------------------------------------------------------
module uyvyrot_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output uyvyrot_pkg::fifo_status_t  status_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

### sv/uyvyrot_front.sv
// ---------------------------------------------------------------------------
// uyvyrot_front
// Config registers, frame geometry and command classification: tracks load
// and output positions and queues store writes and paired store reads.
// ---------------------------------------------------------------------------
module uyvyrot_front #(
  parameter int unsigned MaxWidth  = uyvyrot_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = uyvyrot_pkg::DefMaxHeight,
  localparam int unsigned Depth    = (MaxWidth / 2) * MaxHeight,
  localparam int unsigned CntW     = $clog2(Depth + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [9:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic [7:0]               in_u_i,
  input  logic [7:0]               in_y0_i,
  input  logic [7:0]               in_v_i,
  input  logic [7:0]               in_y1_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output uyvyrot_pkg::op_t         op_o,
  output logic [CntW-1:0]          addr_a_o,
  output logic [CntW-1:0]          addr_b_o,
  output logic [31:0]              wdata_o
);

  localparam int unsigned LimW0 = MaxWidth - (MaxWidth % 2);
  localparam int unsigned LimH0 = MaxHeight - (MaxHeight % 2);
  localparam int unsigned LimW  = (LimW0 < 2) ? 2 : LimW0;
  localparam int unsigned LimH  = (LimH0 < 2) ? 2 : LimH0;

  logic [9:0]      width_q;
  logic [8:0]      height_q;
  logic            ccw_q;
  logic            settle_q;
  logic            fresh_q;
  logic [CntW-1:0] load_q;
  logic [9:0]      row_q;
  logic [7:0]      pair_q;
  logic [9:0]      col_q;
  logic [CntW-1:0] ia_q;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] corner_q, corner_d;

  logic [9:0]      w_even, w_eff;
  logic [8:0]      h_even, h_eff;
  logic [8:0]      hw;
  logic [7:0]      hh;
  logic            cfg_we, cfg_hit, accept, is_emit;
  logic [CntW-1:0] ia_cur, ib_cur, ia_row, ia_step, row_base;
  logic [9:0]      col_cur, col_next;
  logic            data_ok, load_ok, last, pair_wrap;

  always_comb begin
    w_even = {width_q[9:1], 1'b0};
    if (w_even < 10'd2) begin
      w_eff = 10'd2;
    end else if (32'(w_even) > LimW) begin
      w_eff = 10'(LimW);
    end else begin
      w_eff = w_even;
    end
    h_even = {height_q[8:1], 1'b0};
    if (h_even < 9'd2) begin
      h_eff = 9'd2;
    end else if (32'(h_even) > LimH) begin
      h_eff = 9'(LimH);
    end else begin
      h_eff = h_even;
    end
  end

  assign hw       = w_eff[9:1];
  assign hh       = h_eff[8:1];
  assign total_d  = CntW'(18'(hw) * 18'(h_eff));
  assign corner_d = CntW'(18'(hw) * 18'(h_eff - 9'd2));

  always_comb begin
    cfg_hit = 1'b0;
    unique case (uyvyrot_pkg::cfg_reg_e'(cfg_index_i))
      uyvyrot_pkg::REG_WIDTH,
      uyvyrot_pkg::REG_HEIGHT,
      uyvyrot_pkg::REG_DIRECTION: cfg_hit = 1'b1;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  assign cfg_we     = cfg_valid_i && cfg_hit;
  assign in_ready_o = !settle_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_emit    = (uyvyrot_pkg::cmd_e'(command_i) == uyvyrot_pkg::CMD_EMIT);

  always_comb begin
    if (fresh_q) begin
      ia_cur  = ccw_q ? CntW'(hw - 9'd1) : corner_q;
      col_cur = ccw_q ? (w_eff - 10'd1) : 10'd0;
    end else begin
      ia_cur  = ia_q;
      col_cur = col_q;
    end
  end

  assign ib_cur    = ia_cur + CntW'(hw);
  assign data_ok   = (ib_cur < load_q);
  assign load_ok   = (load_q < total_q);
  assign pair_wrap = (pair_q == hh - 8'd1);
  assign last      = (row_q == w_eff - 10'd1) && pair_wrap;
  assign col_next  = ccw_q ? (col_cur - 10'd1) : (col_cur + 10'd1);
  assign row_base  = ccw_q ? '0 : corner_q;
  assign ia_row    = row_base + CntW'(col_next[9:1]);
  assign ia_step   = ccw_q ? (ia_cur + CntW'(w_eff)) : (ia_cur - CntW'(w_eff));

  assign push_o       = accept && (is_emit ? data_ok : load_ok);
  assign op_o.is_read = is_emit;
  assign op_o.odd     = col_cur[0];
  assign op_o.ccw     = ccw_q;
  assign op_o.last    = last;
  assign addr_a_o     = is_emit ? ia_cur : load_q;
  assign addr_b_o     = ib_cur;
  assign wdata_o      = {in_y1_i, in_v_i, in_y0_i, in_u_i};

  always_ff @(posedge clk_i) begin
    total_q  <= total_d;
    corner_q <= corner_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= uyvyrot_pkg::WidthReset;
      height_q <= uyvyrot_pkg::HeightReset;
      ccw_q    <= 1'b0;
      settle_q <= 1'b1;
      fresh_q  <= 1'b1;
      load_q   <= '0;
      row_q    <= '0;
      pair_q   <= '0;
      col_q    <= '0;
      ia_q     <= '0;
    end else begin
      settle_q <= 1'b0;
      if (cfg_we) begin
        unique case (uyvyrot_pkg::cfg_reg_e'(cfg_index_i))
          uyvyrot_pkg::REG_WIDTH:     width_q  <= cfg_data_i;
          uyvyrot_pkg::REG_HEIGHT:    height_q <= cfg_data_i[8:0];
          uyvyrot_pkg::REG_DIRECTION: ccw_q    <= cfg_data_i[0];
          default:                    ccw_q    <= ccw_q;
        endcase
        settle_q <= 1'b1;
        fresh_q  <= 1'b1;
        load_q   <= '0;
        row_q    <= '0;
        pair_q   <= '0;
      end else if (accept) begin
        if (!is_emit) begin
          if (load_ok) begin
            load_q <= load_q + CntW'(1);
          end
        end else if (data_ok) begin
          if (last) begin
            fresh_q <= 1'b1;
            load_q  <= '0;
            row_q   <= '0;
            pair_q  <= '0;
          end else if (pair_wrap) begin
            fresh_q <= 1'b0;
            pair_q  <= '0;
            row_q   <= row_q + 10'd1;
            col_q   <= col_next;
            ia_q    <= ia_row;
          end else begin
            fresh_q <= 1'b0;
            pair_q  <= pair_q + 8'd1;
            col_q   <= col_cur;
            ia_q    <= ia_step;
          end
        end
      end
    end
  end

endmodule

### sv/uyvyrot_back.sv
// ---------------------------------------------------------------------------
// uyvyrot_back
// Single-port frame store and sequencer: performs queued writes, reads the
// two source words of an output macropixel and drives the output register.
// ---------------------------------------------------------------------------
module uyvyrot_back #(
  parameter int unsigned MaxWidth  = uyvyrot_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = uyvyrot_pkg::DefMaxHeight,
  localparam int unsigned Depth    = (MaxWidth / 2) * MaxHeight,
  localparam int unsigned CntW     = $clog2(Depth + 1),
  localparam int unsigned AddrW    = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  uyvyrot_pkg::fifo_status_t q_status_i,
  output logic                      pop_o,
  input  uyvyrot_pkg::op_t          op_i,
  input  logic [CntW-1:0]           addr_a_i,
  input  logic [CntW-1:0]           addr_b_i,
  input  logic [31:0]               wdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_u_o,
  output logic [7:0]                out_y0_o,
  output logic [7:0]                out_v_o,
  output logic [7:0]                out_y1_o,
  output logic                      frame_last_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RDB  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_HOLD = 4'b1000
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [31:0]       mem_q [Depth];
  logic [31:0]       rdata_q;
  logic [31:0]       wa_q, wb_q;
  uyvyrot_pkg::op_t  op_q;
  logic [AddrW-1:0]  addr_b_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic              out_valid_q, out_valid_d;
  logic              out_free, out_load;
  logic [31:0]       word_b;
  logic [7:0]        luma_a, luma_b;
  logic [7:0]        out_u_q, out_y0_q, out_v_q, out_y1_q;
  logic              last_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign word_b   = state_q[3] ? wb_q : rdata_q;
  assign luma_a   = uyvyrot_pkg::luma_at(wa_q, op_q.odd);
  assign luma_b   = uyvyrot_pkg::luma_at(word_b, op_q.odd);

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = addr_a_i[AddrW-1:0];
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          if (op_i.is_read) begin
            mem_re  = 1'b1;
            state_d = ST_RDB;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_RDB: begin
        mem_re   = 1'b1;
        mem_addr = addr_b_q;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wdata_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !q_status_i.empty && op_i.is_read) begin
      op_q     <= op_i;
      addr_b_q <= addr_b_i[AddrW-1:0];
    end
    if (state_q == ST_RDB) begin
      wa_q <= rdata_q;
    end
    if (state_q == ST_FIN) begin
      wb_q <= rdata_q;
    end
    if (out_load) begin
      out_u_q  <= wa_q[7:0];
      out_v_q  <= wa_q[23:16];
      out_y0_q <= op_q.ccw ? luma_a : luma_b;
      out_y1_q <= op_q.ccw ? luma_b : luma_a;
      last_q   <= op_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_u_o      = out_u_q;
  assign out_y0_o     = out_y0_q;
  assign out_v_o      = out_v_q;
  assign out_y1_o     = out_y1_q;
  assign frame_last_o = last_q;

endmodule

### sv/uyvy_frame_rotate_90_270_core.sv
// ---------------------------------------------------------------------------
// uyvy_frame_rotate_90_270_core
// Rotates a packed UYVY frame by 90 degrees clockwise or counterclockwise.
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//  in        in_valid_i/in_ready_o   command_i, in_u_i, in_y0_i, in_v_i, in_y1_i
//  out       out_valid_o/out_ready_i out_u_o, out_y0_o, out_v_o, out_y1_o,
//                                    frame_last_o
//
// The front takes one word per cycle into a two-word queue while the queue
// has room. In the back a load is a single store write; an emit reads its two
// words from the single-port frame store in turn, then loads the output register.
// Input is held off the cycle after reset and after each non-spare config write.
// A stalled output holds the back, which then backs up the queue and input.
// ---------------------------------------------------------------------------
module uyvy_frame_rotate_90_270_core #(
  parameter int unsigned MaxWidth  = uyvyrot_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = uyvyrot_pkg::DefMaxHeight
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] in_u_i,
  input  logic [7:0] in_y0_i,
  input  logic [7:0] in_v_i,
  input  logic [7:0] in_y1_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_u_o,
  output logic [7:0] out_y0_o,
  output logic [7:0] out_v_o,
  output logic [7:0] out_y1_o,
  output logic       frame_last_o
);

  localparam int unsigned Depth = (MaxWidth / 2) * MaxHeight;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned QW    = uyvyrot_pkg::OpBits + 2 * CntW + 32;

  logic                      push, pop;
  uyvyrot_pkg::op_t          f_op, b_op;
  logic [CntW-1:0]           f_addr_a, f_addr_b, b_addr_a, b_addr_b;
  logic [31:0]               f_wdata, b_wdata;
  logic [QW-1:0]             q_in, q_out;
  uyvyrot_pkg::fifo_status_t q_status;

  assign cfg_ready_o = 1'b1;

  uyvyrot_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .in_u_i      (in_u_i),
    .in_y0_i     (in_y0_i),
    .in_v_i      (in_v_i),
    .in_y1_i     (in_y1_i),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .op_o        (f_op),
    .addr_a_o    (f_addr_a),
    .addr_b_o    (f_addr_b),
    .wdata_o     (f_wdata)
  );

  assign q_in = {f_op, f_addr_a, f_addr_b, f_wdata};

  uyvyrot_fifo #(
    .Width (QW)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (q_in),
    .pop_i    (pop),
    .data_o   (q_out),
    .status_o (q_status)
  );

  assign {b_op, b_addr_a, b_addr_b, b_wdata} = q_out;

  uyvyrot_back #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .op_i         (b_op),
    .addr_a_i     (b_addr_a),
    .addr_b_i     (b_addr_b),
    .wdata_i      (b_wdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_u_o      (out_u_o),
    .out_y0_o     (out_y0_o),
    .out_v_o      (out_v_o),
    .out_y1_o     (out_y1_o),
    .frame_last_o (frame_last_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue pop while empty");

  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o &&
     (cfg_index_i == uyvyrot_pkg::REG_WIDTH || cfg_index_i == uyvyrot_pkg::REG_HEIGHT ||
      cfg_index_i == uyvyrot_pkg::REG_DIRECTION)) |=> !in_ready_o)
    else $error("input taken right after config write");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UYVY 90/270 frame rotator core.
// Load and emit words go in over a bursty valid/ready sender while the output
// side stalls on its own pattern. Every accepted input word runs through a
// local rotation model that keeps its own frame store and counters, and each
// macropixel that the model says comes out is queued and compared field by
// field with the next output word. Directed tests cover minimum and odd
// sizes, both directions, frame full, missing data, end of pass, config
// restart and the spare register index; then the largest sizes, then random
// frames with noise and aborted frames.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxWidth   = uyvyrot_pkg::DefMaxWidth;
  localparam int unsigned MaxHeight  = uyvyrot_pkg::DefMaxHeight;
  localparam int unsigned StoreDepth = (MaxWidth / 2) * MaxHeight;
  localparam int unsigned RandItems  = 1750;
  localparam int unsigned Settle     = 16;
  localparam int unsigned IdleLimit  = 5000;
  localparam logic [1:0]  RegSpare   = 2'd3;

  typedef struct packed {
    logic [7:0] u;
    logic [7:0] y0;
    logic [7:0] v;
    logic [7:0] y1;
    logic       last;
  } rot_pix_t;

  typedef enum logic [1:0] {
    STEP_IGNORED,
    STEP_STORED,
    STEP_EMITTED
  } step_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [9:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  uyvyrot_pkg::cmd_e in_cmd = uyvyrot_pkg::CMD_LOAD;
  logic [7:0]        in_u = '0;
  logic [7:0]        in_y0 = '0;
  logic [7:0]        in_v = '0;
  logic [7:0]        in_y1 = '0;
  logic              out_ready = 1'b0;

  logic       cfg_ready_o;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_u_o;
  logic [7:0] out_y0_o;
  logic [7:0] out_v_o;
  logic [7:0] out_y1_o;
  logic       frame_last_o;

  // rotation model state
  bit [31:0]   frame_mem [StoreDepth];
  int unsigned fill_idx;
  int unsigned out_line;
  int unsigned out_pair;
  logic [9:0]  cfg_w;
  logic [8:0]  cfg_h;
  logic        cfg_ccw;
  rot_pix_t    pending_q[$];

  int unsigned err_cnt;
  int unsigned frames_done;
  int unsigned useful_cnt;
  int unsigned stored_cnt;
  int unsigned dropped_cnt;
  int unsigned idle_emit_cnt;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned burst_left;
  int unsigned gap;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned stall_mode;

  uyvy_frame_rotate_90_270_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .command_i    (in_cmd),
    .in_u_i       (in_u),
    .in_y0_i      (in_y0),
    .in_v_i       (in_v),
    .in_y1_i      (in_y1),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .out_u_o      (out_u_o),
    .out_y0_o     (out_y0_o),
    .out_v_o      (out_v_o),
    .out_y1_o     (out_y1_o),
    .frame_last_o (frame_last_o)
  );

  always #2 clk = ~clk;

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
    int unsigned lim;
    int unsigned e;
    lim = maxv & ~32'd1;
    e   = v & ~32'd1;
    if (lim < 2) lim = 2;
    if (e < 2) e = 2;
    if (e > lim) e = lim;
    return e;
  endfunction

  function automatic logic [7:0] pick_luma(input logic [31:0] word, input int unsigned col);
    return col[0] ? word[31:24] : word[15:8];
  endfunction

  task automatic model_cfg(input logic [1:0] idx, input logic [9:0] data);
    case (idx)
      uyvyrot_pkg::REG_WIDTH:     cfg_w = data;
      uyvyrot_pkg::REG_HEIGHT:    cfg_h = data[8:0];
      uyvyrot_pkg::REG_DIRECTION: cfg_ccw = data[0];
      default:                    return;
    endcase
    fill_idx = 0;
    out_line = 0;
    out_pair = 0;
  endtask

  task automatic rotate_step(input uyvyrot_pkg::cmd_e cmd, input logic [31:0] word,
                             output step_e st);
    int unsigned w, h, hw, hh, top, col, ia, ib;
    logic [31:0] wa, wb;
    rot_pix_t pix;
    w  = eff_dim(32'(cfg_w), MaxWidth);
    h  = eff_dim(32'(cfg_h), MaxHeight);
    hw = w / 2;
    hh = h / 2;
    st = STEP_IGNORED;
    if (cmd == uyvyrot_pkg::CMD_LOAD) begin
      if (fill_idx < hw * h && fill_idx < StoreDepth) begin
        frame_mem[fill_idx] = word;
        fill_idx++;
        st = STEP_STORED;
      end
      return;
    end
    if (out_line >= w || out_pair >= hh) begin
      out_line = 0;
      out_pair = 0;
    end
    if (!cfg_ccw) begin
      top = h - 2 - 2 * out_pair;
      col = out_line;
    end else begin
      top = 2 * out_pair;
      col = w - 1 - out_line;
    end
    ia = top * hw + col / 2;
    ib = ia + hw;
    if (ib >= fill_idx || ib >= StoreDepth) return;
    wa = frame_mem[ia];
    wb = frame_mem[ib];
    pix.u  = wa[7:0];
    pix.v  = wa[23:16];
    pix.y0 = cfg_ccw ? pick_luma(wa, col) : pick_luma(wb, col);
    pix.y1 = cfg_ccw ? pick_luma(wb, col) : pick_luma(wa, col);
    pix.last = (out_line == w - 1) && (out_pair == hh - 1);
    pending_q.push_back(pix);
    st = STEP_EMITTED;
    if (pix.last) begin
      out_line = 0;
      out_pair = 0;
      fill_idx = 0;
      frames_done++;
    end else if (out_pair + 1 >= hh) begin
      out_pair = 0;
      out_line++;
    end else begin
      out_pair++;
    end
  endtask

  // one word on the input channel, bursty
  task automatic send_word(input uyvyrot_pkg::cmd_e cmd, input logic [31:0] word);
    step_e st;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_u     <= word[7:0];
    in_y0    <= word[15:8];
    in_v     <= word[23:16];
    in_y1    <= word[31:24];
    do @(posedge clk); while (!in_ready_o);
    rotate_step(cmd, word, st);
    case (st)
      STEP_STORED:  begin stored_cnt++; useful_cnt++; end
      STEP_EMITTED: useful_cnt++;
      default: begin
        if (cmd == uyvyrot_pkg::CMD_LOAD) dropped_cnt++;
        else idle_emit_cnt++;
      end
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    model_cfg(idx, data);
    cfg_writes++;
  endtask

  task automatic set_frame(input logic [9:0] w, input logic [9:0] h, input logic ccw);
    write_reg(uyvyrot_pkg::REG_WIDTH, w);
    write_reg(uyvyrot_pkg::REG_HEIGHT, h);
    write_reg(uyvyrot_pkg::REG_DIRECTION, {9'($urandom()), ccw});
  endtask

  // loads one frame in raster order with emits mixed in; optionally aborted
  task automatic run_frame(input bit broken);
    int unsigned total, loaded, n, abort_at, start;
    total    = (eff_dim(32'(cfg_w), MaxWidth) / 2) * eff_dim(32'(cfg_h), MaxHeight);
    loaded   = 0;
    n        = 0;
    start    = frames_done;
    abort_at = broken ? $urandom_range(1, 2 * total) : 0;
    while (frames_done == start) begin
      if (abort_at != 0 && n == abort_at) break;
      if (loaded < total && $urandom_range(0, 3) != 0) begin
        send_word(uyvyrot_pkg::CMD_LOAD, $urandom());
        loaded++;
      end else if (loaded >= total && $urandom_range(0, 15) == 0) begin
        send_word(uyvyrot_pkg::CMD_LOAD, $urandom());
      end else begin
        send_word(uyvyrot_pkg::CMD_EMIT, $urandom());
      end
      n++;
    end
  endtask

  task automatic test_reset_state();
    send_word(uyvyrot_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    send_word(uyvyrot_pkg::CMD_EMIT, 32'h0000_0000);
  endtask

  task automatic test_min_frame_cw();
    set_frame(10'd0, 10'd1, 1'b0);
    send_word(uyvyrot_pkg::CMD_EMIT, 32'hFFFF_FFFF);
    send_word(uyvyrot_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    send_word(uyvyrot_pkg::CMD_LOAD, 32'h0000_0000);
    send_word(uyvyrot_pkg::CMD_EMIT, 32'h0000_0000);
    send_word(uyvyrot_pkg::CMD_EMIT, 32'h0000_0000);
    send_word(uyvyrot_pkg::CMD_EMIT, 32'hFFFF_FFFF);
    send_word(uyvyrot_pkg::CMD_LOAD, 32'h1234_5678);
    send_word(uyvyrot_pkg::CMD_LOAD, 32'h9ABC_DEF0);
    send_word(uyvyrot_pkg::CMD_EMIT, 32'h0000_0000);
    send_word(uyvyrot_pkg::CMD_EMIT, 32'h0000_0000);
  endtask

  task automatic test_ccw_odd_full();
    set_frame(10'd5, 10'd3, 1'b1);
    repeat (5) send_word(uyvyrot_pkg::CMD_LOAD, $urandom());
    repeat (4) send_word(uyvyrot_pkg::CMD_EMIT, $urandom());
  endtask

  task automatic test_spare_reg();
    set_frame(10'd2, 10'd2, 1'b0);
    send_word(uyvyrot_pkg::CMD_LOAD, $urandom());
    write_reg(RegSpare, 10'($urandom()));
    send_word(uyvyrot_pkg::CMD_LOAD, $urandom());
    repeat (2) send_word(uyvyrot_pkg::CMD_EMIT, $urandom());
  endtask

  task automatic test_cfg_restart();
    send_word(uyvyrot_pkg::CMD_LOAD, $urandom());
    write_reg(uyvyrot_pkg::REG_DIRECTION, 10'd1);
    repeat (2) send_word(uyvyrot_pkg::CMD_LOAD, $urandom());
    repeat (2) send_word(uyvyrot_pkg::CMD_EMIT, $urandom());
  endtask

  task automatic test_max_sizes();
    set_frame(10'd1023, 10'd0, 1'b1);
    run_frame(1'b0);
    set_frame(10'd1, 10'd511, 1'b0);
    run_frame(1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned base, sel, first;
    logic [9:0] w, h;
    bit clean;
    base  = useful_cnt;
    clean = 1'b1;
    while (useful_cnt - base < RandItems) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        w = 10'($urandom_range(21, 1023));
        h = 10'($urandom_range(0, 3));
      end else if (sel == 1) begin
        w = 10'($urandom_range(0, 3));
        h = 10'($urandom_range(21, 511));
      end else begin
        w = 10'($urandom_range(0, 17));
        h = 10'($urandom_range(0, 17));
      end
      // a clean previous pass lets the next load start a new frame on its own
      if (!(clean && $urandom_range(0, 3) == 0)) begin
        first = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
          case ((first + k) % 3)
            0: write_reg(uyvyrot_pkg::REG_WIDTH, w);
            1: write_reg(uyvyrot_pkg::REG_HEIGHT, h);
            default: write_reg(uyvyrot_pkg::REG_DIRECTION, 10'($urandom()));
          endcase
        end
        if ($urandom_range(0, 5) == 0) write_reg(RegSpare, 10'($urandom()));
      end else if ($urandom_range(0, 1) == 0) begin
        wait_drained();
      end
      clean = ($urandom_range(0, 7) != 0);
      run_frame(!clean);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ((stall_left % 16) > 10);
    endcase
  end

  always @(posedge clk) begin
    rot_pix_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected word u=%02h y0=%02h v=%02h y1=%02h last=%0b", $time,
                   out_u_o, out_y0_o, out_v_o, out_y1_o, frame_last_o);
      end else begin
        want = pending_q.pop_front();
        results_seen++;
        if (out_u_o !== want.u || out_y0_o !== want.y0 || out_v_o !== want.v ||
            out_y1_o !== want.y1 || frame_last_o !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: exp %02h %02h %02h %02h %0b, got %02h %02h %02h %02h %0b",
                     $time, want.u, want.y0, want.v, want.y1, want.last,
                     out_u_o, out_y0_o, out_v_o, out_y1_o, frame_last_o);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no word moved for %0d cycles, %0d results pending", IdleLimit,
               pending_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    cfg_w   = uyvyrot_pkg::WidthReset;
    cfg_h   = uyvyrot_pkg::HeightReset;
    cfg_ccw = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_min_frame_cw();
    test_ccw_odd_full();
    test_spare_reg();
    test_cfg_restart();
    test_max_sizes();
    test_random_frames();
    wait_drained();
    $display("summary: %0d words in, %0d stored, %0d loads dropped, %0d emits idle",
             stored_cnt + dropped_cnt + idle_emit_cnt + results_seen, stored_cnt, dropped_cnt,
             idle_emit_cnt);
    $display("summary: %0d rotated words checked, %0d frames completed, %0d config writes",
             results_seen, frames_done, cfg_writes);
    if (err_cnt == 0 && pending_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
